// ===== hw/rtl/tsc_pkg.sv =====
`default_nettype none

package tsc_pkg;

    // field and register widths
    localparam int SAMPLE_W = 16;
    localparam int MV_W     = 14;
    localparam int TEMP_W   = 19;
    localparam int STAT_W   = 2;
    localparam int COEFF_W  = 32;
    localparam int SERIES_W = 20;
    localparam int REF_W    = 13;
    localparam int APB_W    = 32;
    localparam int ADDR_W   = 5;
    localparam int TDATA_W  = 40;

    // log2 unit: q1.30 mantissa, 28 fraction bits
    localparam int MANT_W = 31;
    localparam int FRAC_W = 28;

    // datapath widths after the log units
    localparam int D_W    = 34;
    localparam int D_LO_W = 17;
    localparam int PW     = 54;
    localparam int WW     = 80;
    localparam int L_W    = 30;
    localparam int LL_W   = 36;
    localparam int LL_LO  = 18;
    localparam int L3_W   = 42;
    localparam int L3_LO  = 21;
    localparam int T2_W   = 38;
    localparam int T3_W   = 50;
    localparam int SUM_W  = 51;
    localparam int INV_W  = 53;
    localparam int DEN_W  = 52;
    localparam int Q_W    = 18;
    localparam int CMP_W  = DEN_W + Q_W;

    localparam logic [27:0]       LN2_Q28  = 28'd186065279;
    localparam logic [DEN_W-1:0]  NUM_BASE = DEN_W'(100) << 40;
    localparam logic [Q_W-1:0]    Q_MAX    = Q_W'(177315);
    localparam logic [TEMP_W-1:0] TEMP_OFS = TEMP_W'(27315);
    localparam logic [TEMP_W-1:0] TEMP_MIN = -TEMP_W'(27315);
    localparam logic [TEMP_W-1:0] TEMP_MAX = TEMP_W'(150000);
    localparam logic [MV_W-1:0]   MV_LIM   = MV_W'(5000);

    // register reset values
    localparam logic [COEFF_W-1:0]  COEFF_A_RST = 32'd1241511355;
    localparam logic [COEFF_W-1:0]  COEFF_B_RST = 32'd257423160;
    localparam logic [COEFF_W-1:0]  COEFF_C_RST = 32'd96399;
    localparam logic [SERIES_W-1:0] SERIES_RST  = 20'd10000;
    localparam logic [REF_W-1:0]    REF_HI_RST  = 13'd3300;
    localparam logic [REF_W-1:0]    REF_LO_RST  = 13'd0;

    typedef enum logic [STAT_W-1:0] {
        ST_VALID = 2'd0,
        ST_ZERO  = 2'd1,
        ST_SAT   = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        REG_COEFF_A = 3'd0,
        REG_COEFF_B = 3'd1,
        REG_COEFF_C = 3'd2,
        REG_SERIES  = 3'd3,
        REG_REF_HI  = 3'd4,
        REG_REF_LO  = 3'd5
    } reg_idx_t;

    // side info carried next to the log units
    typedef struct packed {
        logic            vld;
        logic [MV_W-1:0] mv;
        logic            zero;
        logic            sat;
    } side_t;

    // item state through the back half of the pipe
    typedef struct packed {
        logic              vld;
        logic [MV_W-1:0]   mv;
        logic              zero;
        logic              sat;
        logic              neg;
        logic [D_W-1:0]    d;
        logic [PW-1:0]     pa;
        logic [PW-1:0]     pb;
        logic [L_W-1:0]    l;
        logic [LL_W-1:0]   ll;
        logic [L3_W-1:0]   l3;
        logic [T2_W-1:0]   t2;
        logic [T3_W-1:0]   t3;
        logic [SUM_W-1:0]  sum;
        logic [INV_W-1:0]  inv;
        logic              dbad;
        logic              ovf;
        logic [DEN_W-1:0]  den;
        logic [DEN_W-1:0]  rem;
        logic [Q_W-1:0]    q;
        logic [TEMP_W-1:0] temp;
        status_t           stat;
    } stage_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsc_log2_pipe.sv =====
`default_nettype none

module tsc_log2_pipe import tsc_pkg::*; #(
    parameter int IN_W = 16
) (
    input  logic                            aclk,
    input  logic                            en,
    input  logic [IN_W-1:0]                 x,
    output logic [$clog2(IN_W)+FRAC_W-1:0]  y
);

    localparam int EW = $clog2(IN_W);
    localparam int NW = IN_W + MANT_W - 1;

    logic [IN_W-1:0]     x0_reg;
    logic [EW-1:0]       e0_reg;
    logic [EW-1:0]       e_lead;
    logic [NW-1:0]       shifted;
    logic [MANT_W-1:0]   m_reg [0:FRAC_W];
    logic [FRAC_W-1:0]   f_reg [0:FRAC_W];
    logic [EW-1:0]       e_reg [0:FRAC_W];
    logic [MANT_W-1:0]   m_next [1:FRAC_W];
    logic [FRAC_W-1:0]   f_next [1:FRAC_W];
    logic [2*MANT_W-1:0] sq [1:FRAC_W];

    // position of the leading one
    always_comb begin
        e_lead = '0;
        for (int i = 0; i < IN_W; i++) begin
            if (x[i]) begin
                e_lead = EW'(i);
            end
        end
    end

    // normalize to q1.30
    assign shifted = {x0_reg, {(MANT_W-1){1'b0}}} >> e0_reg;

    // one squaring per stage, one fraction bit each
    always_comb begin
        for (int j = 1; j <= FRAC_W; j++) begin
            sq[j] = (2*MANT_W)'(m_reg[j-1]) * (2*MANT_W)'(m_reg[j-1]);
            if (sq[j][2*MANT_W-1]) begin
                m_next[j] = sq[j][2*MANT_W-1 -: MANT_W];
                f_next[j] = f_reg[j-1] | (FRAC_W'(1) << (FRAC_W - j));
            end else begin
                m_next[j] = sq[j][2*MANT_W-2 -: MANT_W];
                f_next[j] = f_reg[j-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x0_reg   <= x;
            e0_reg   <= e_lead;
            m_reg[0] <= shifted[MANT_W-1:0];
            f_reg[0] <= '0;
            e_reg[0] <= e0_reg;
            for (int j = 1; j <= FRAC_W; j++) begin
                m_reg[j] <= m_next[j];
                f_reg[j] <= f_next[j];
                e_reg[j] <= e_reg[j-1];
            end
        end
    end

    assign y = {e_reg[FRAC_W], f_reg[FRAC_W]};

endmodule

`default_nettype wire

// ===== hw/rtl/thermistor_sample_to_celsius.sv =====
// an accepted input beat passes the front registers, the two log2 units beside the side delay line, then the back half
// throughput: one sample per cycle; every stage holds while a result beat waits on m_tready
// the depth is set by the two log2 units (one squaring per fraction bit)
// and the restoring divider (one quotient bit per stage)
// reset: aresetn synchronous active low, clears valid bits and loads register defaults
`default_nettype none

module thermistor_sample_to_celsius import tsc_pkg::*; #(
    parameter int ADC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // apb register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]   prdata,
    output logic               pready,
    // sample stream
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [SAMPLE_W-1:0] s_tdata,  // [15:0] sample
    // result stream
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // [13:0] millivolts, [32:14] temp_centi, zero fill
    output logic [STAT_W-1:0]  m_tuser    // [1:0] status
);

    localparam int LOG_LAT   = FRAC_W + 2;
    localparam int LN_IN_W   = SERIES_W + ADC_BITS + 1;
    localparam int LN_OUT_W  = $clog2(LN_IN_W) + FRAC_W;
    localparam int LD_OUT_W  = $clog2(ADC_BITS) + FRAC_W;
    localparam int DIV_FIRST = 12;
    localparam int NSTG      = DIV_FIRST + Q_W + 1;
    localparam int FULL_W    = ADC_BITS + 1;
    localparam int PM_W      = REF_W + 1 + SAMPLE_W;

    // configuration registers
    logic [COEFF_W-1:0]  coeff_a_reg, coeff_b_reg, coeff_c_reg;
    logic [SERIES_W-1:0] series_reg;
    logic [REF_W-1:0]    ref_hi_reg, ref_lo_reg;
    logic                cfg_wr;
    reg_idx_t            cfg_idx;

    // pipeline control
    logic adv;

    // front stage
    side_t               t1_next, t1_reg;
    logic [LN_IN_W-1:0]  xn_next, xn_reg;
    logic [ADC_BITS-1:0] xs_reg;
    logic [FULL_W-1:0]   full, rest;
    logic [MV_W-1:0]     ref_diff, ref_mag, mv_mag;
    logic [PM_W-1:0]     mv_prod;

    // log lanes and side delay line
    side_t               sd_reg [0:LOG_LAT-1];
    logic [LN_OUT_W-1:0] ln_y;
    logic [LD_OUT_W-1:0] ld_y;

    // back half
    stage_t st_reg [0:NSTG-1];
    stage_t st_next [0:NSTG-1];

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = reg_idx_t'(paddr[ADDR_W-1:2]);

    // the whole pipe moves unless the result beat is stuck
    assign adv      = ~st_reg[NSTG-1].vld | m_tready;
    assign s_tready = adv;

    // ------------------------------------------------------------------
    // register port
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_a_reg <= COEFF_A_RST;
            coeff_b_reg <= COEFF_B_RST;
            coeff_c_reg <= COEFF_C_RST;
            series_reg  <= SERIES_RST;
            ref_hi_reg  <= REF_HI_RST;
            ref_lo_reg  <= REF_LO_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_COEFF_A: coeff_a_reg <= pwdata[COEFF_W-1:0];
                REG_COEFF_B: coeff_b_reg <= pwdata[COEFF_W-1:0];
                REG_COEFF_C: coeff_c_reg <= pwdata[COEFF_W-1:0];
                REG_SERIES:  series_reg  <= pwdata[SERIES_W-1:0];
                REG_REF_HI:  ref_hi_reg  <= pwdata[REF_W-1:0];
                REG_REF_LO:  ref_lo_reg  <= pwdata[REF_W-1:0];
                default: ;  // addresses past the map are dropped
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_COEFF_A: prdata = coeff_a_reg;
            REG_COEFF_B: prdata = coeff_b_reg;
            REG_COEFF_C: prdata = coeff_c_reg;
            REG_SERIES:  prdata = APB_W'(series_reg);
            REG_REF_HI:  prdata = APB_W'(ref_hi_reg);
            REG_REF_LO:  prdata = APB_W'(ref_lo_reg);
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // front stage: special cases, divider resistance product, millivolts
    // ------------------------------------------------------------------
    always_comb begin
        full = FULL_W'(1) << ADC_BITS;
        rest = full - FULL_W'(s_tdata);

        // resistance numerator series * (2^n - sample)
        xn_next = LN_IN_W'(series_reg) * LN_IN_W'(rest);

        // reference span, sign kept apart
        ref_diff = MV_W'(ref_hi_reg) - MV_W'(ref_lo_reg);
        ref_mag  = ref_diff[MV_W-1] ? -ref_diff : ref_diff;
        mv_prod  = (PM_W'(ref_mag) * PM_W'(s_tdata)) >> ADC_BITS;
        mv_mag   = (mv_prod > PM_W'(MV_LIM)) ? MV_LIM : mv_prod[MV_W-1:0];

        t1_next.vld  = s_tvalid;
        t1_next.mv   = ref_diff[MV_W-1] ? -mv_mag : mv_mag;
        t1_next.zero = (s_tdata == '0);
        // sample at or past full scale, or no divider resistance
        t1_next.sat  = ((s_tdata >> ADC_BITS) != '0) || (series_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg.vld <= 1'b0;
            for (int k = 0; k < LOG_LAT; k++) begin
                sd_reg[k].vld <= 1'b0;
            end
        end else if (adv) begin
            t1_reg    <= t1_next;
            sd_reg[0] <= t1_reg;
            for (int k = 1; k < LOG_LAT; k++) begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xn_reg <= xn_next;
            xs_reg <= s_tdata[ADC_BITS-1:0];
        end
    end

    // ------------------------------------------------------------------
    // log2 of numerator and of sample, one lane each
    // ------------------------------------------------------------------
    tsc_log2_pipe #(.IN_W(LN_IN_W)) u_log_num (
        .aclk (aclk),
        .en   (adv),
        .x    (xn_reg),
        .y    (ln_y)
    );

    tsc_log2_pipe #(.IN_W(ADC_BITS)) u_log_smp (
        .aclk (aclk),
        .en   (adv),
        .x    (xs_reg),
        .y    (ld_y)
    );

    // ------------------------------------------------------------------
    // back half: ln scaling, steinhart-hart cubic, reciprocal
    // ------------------------------------------------------------------
    always_comb begin
        logic [WW-1:0]    w0, w1;
        logic [D_W-1:0]   ln_e, ld_e;
        logic [CMP_W-1:0] dk;
        logic [INV_W-1:0] a_e;

        ln_e = D_W'(ln_y);
        ld_e = D_W'(ld_y);
        a_e  = INV_W'(coeff_a_reg);

        for (int k = 1; k < NSTG; k++) begin
            st_next[k] = st_reg[k-1];
        end

        // stage 0: log ratio, sign split off
        st_next[0]      = st_reg[0];
        st_next[0].vld  = sd_reg[LOG_LAT-1].vld;
        st_next[0].mv   = sd_reg[LOG_LAT-1].mv;
        st_next[0].zero = sd_reg[LOG_LAT-1].zero;
        st_next[0].sat  = sd_reg[LOG_LAT-1].sat;
        st_next[0].neg  = ln_e < ld_e;
        st_next[0].d    = (ln_e < ld_e) ? (ld_e - ln_e) : (ln_e - ld_e);

        // stage 1-2: ln = d * ln2, in two partial products
        st_next[1].pa = PW'(st_reg[0].d[D_LO_W-1:0]) * PW'(LN2_Q28);
        st_next[1].pb = PW'(st_reg[0].d[D_W-1:D_LO_W]) * PW'(LN2_Q28);
        w0 = (WW'(st_reg[1].pb) << D_LO_W) + WW'(st_reg[1].pa);
        st_next[2].l = w0[32 +: L_W];

        // stage 3: l squared, linear term
        w0 = WW'(st_reg[2].l) * WW'(st_reg[2].l);
        w1 = WW'(st_reg[2].l) * WW'(coeff_b_reg);
        st_next[3].ll = w0[24 +: LL_W];
        st_next[3].t2 = w1[24 +: T2_W];

        // stage 4-5: l cubed
        st_next[4].pa = PW'(st_reg[3].ll[LL_LO-1:0]) * PW'(st_reg[3].l);
        st_next[4].pb = PW'(st_reg[3].ll[LL_W-1:LL_LO]) * PW'(st_reg[3].l);
        w0 = (WW'(st_reg[4].pb) << LL_LO) + WW'(st_reg[4].pa);
        st_next[5].l3 = w0[24 +: L3_W];

        // stage 6-7: cubic term
        st_next[6].pa = PW'(st_reg[5].l3[L3_LO-1:0]) * PW'(coeff_c_reg);
        st_next[6].pb = PW'(st_reg[5].l3[L3_W-1:L3_LO]) * PW'(coeff_c_reg);
        w0 = (WW'(st_reg[6].pb) << L3_LO) + WW'(st_reg[6].pa);
        st_next[7].t3 = w0[24 +: T3_W];

        // stage 8-9: inverse kelvin
        st_next[8].sum = SUM_W'(st_reg[7].t2) + SUM_W'(st_reg[7].t3);
        st_next[9].inv = st_reg[8].neg ? (a_e - INV_W'(st_reg[8].sum))
                                       : (a_e + INV_W'(st_reg[8].sum));

        // stage 10: divider setup, rounding half of the divisor folded in
        st_next[10].dbad = st_reg[9].inv[INV_W-1] || (st_reg[9].inv == '0);
        st_next[10].den  = st_reg[9].inv[DEN_W-1:0];
        st_next[10].rem  = NUM_BASE + (st_reg[9].inv[DEN_W-1:0] >> 1);

        // stage 11: quotient too big for the range
        st_next[11].ovf = {{Q_W{1'b0}}, st_reg[10].rem} >= {st_reg[10].den, {Q_W{1'b0}}};
        st_next[11].q   = '0;

        // restoring division, one quotient bit per stage
        for (int i = 0; i < Q_W; i++) begin
            dk = CMP_W'(st_reg[DIV_FIRST+i-1].den) << (Q_W - 1 - i);
            if (CMP_W'(st_reg[DIV_FIRST+i-1].rem) >= dk) begin
                st_next[DIV_FIRST+i].rem = st_reg[DIV_FIRST+i-1].rem - dk[DEN_W-1:0];
                st_next[DIV_FIRST+i].q[Q_W-1-i] = 1'b1;
            end
        end

        // last stage: offset to celsius, saturation and status
        if (st_reg[NSTG-2].zero) begin
            st_next[NSTG-1].temp = TEMP_MIN;
            st_next[NSTG-1].stat = ST_ZERO;
        end else if (st_reg[NSTG-2].sat || st_reg[NSTG-2].dbad || st_reg[NSTG-2].ovf
                     || (st_reg[NSTG-2].q > Q_MAX)) begin
            st_next[NSTG-1].temp = TEMP_MAX;
            st_next[NSTG-1].stat = ST_SAT;
        end else begin
            st_next[NSTG-1].temp = TEMP_W'(st_reg[NSTG-2].q) - TEMP_OFS;
            st_next[NSTG-1].stat = ST_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NSTG; k++) begin
                st_reg[k].vld <= 1'b0;
            end
        end else if (adv) begin
            for (int k = 0; k < NSTG; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // result beat straight from the last stage
    assign m_tvalid = st_reg[NSTG-1].vld;
    assign m_tdata  = {{(TDATA_W-MV_W-TEMP_W){1'b0}}, st_reg[NSTG-1].temp,
                       st_reg[NSTG-1].mv};
    assign m_tuser  = st_reg[NSTG-1].stat;

endmodule

`default_nettype wire
